// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top level of the request byte parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`else

`define ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== hdl/hrbp_pkg.sv =====
// Shared types, codes and constants of the request byte parser.
package hrbp_pkg;

    // Width of the Content-Length accumulator and of the stored length.
    localparam int LEN_BITS = 32;

    localparam int BODY_LEN_W = 32;
    localparam int NAME_LEN = 14;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_P     = 8'h50;

    // Method prefix codes: G=1, GE=2, GET=3, P=4, PO=5, POS=6, POST=7.
    localparam logic [2:0] MM_EMPTY     = 3'd0;
    localparam logic [2:0] MM_G         = 3'd1;
    localparam logic [2:0] MM_GET_DONE  = 3'd3;
    localparam logic [2:0] MM_P         = 3'd4;
    localparam logic [2:0] MM_POST_DONE = 3'd7;

    typedef enum logic [2:0] {
        CLS_DELIM,
        CLS_METHOD,
        CLS_URI,
        CLS_VERSION,
        CLS_NAME,
        CLS_VALUE,
        CLS_BODY
    } byte_class_t;

    typedef enum logic [1:0] {
        METH_NONE,
        METH_GET,
        METH_POST
    } method_t;

    typedef enum logic [1:0] {
        ST_INCOMPLETE,
        ST_COMPLETE,
        ST_FAILED
    } status_t;

    // Result of one decimal digit step on the length accumulator.
    typedef struct packed {
        logic                is_digit;
        logic [3:0]          digit;
        logic                overflow;
        logic [LEN_BITS-1:0] value;
    } acc_result_t;

    // Next expected character after a method prefix; zero where none follows.
    function automatic logic [7:0] meth_next_char(input logic [2:0] m);
        logic [7:0] ch;
        case (m)
            3'd1:    ch = 8'h45;  // E
            3'd2:    ch = 8'h54;  // T
            3'd4:    ch = 8'h4F;  // O
            3'd5:    ch = 8'h53;  // S
            3'd6:    ch = 8'h54;  // T
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Characters of the header name Content-Length.
    function automatic logic [7:0] cl_name_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h43;  // C
            4'd1:    ch = 8'h6F;  // o
            4'd2:    ch = 8'h6E;  // n
            4'd3:    ch = 8'h74;  // t
            4'd4:    ch = 8'h65;  // e
            4'd5:    ch = 8'h6E;  // n
            4'd6:    ch = 8'h74;  // t
            4'd7:    ch = 8'h2D;  // -
            4'd8:    ch = 8'h4C;  // L
            4'd9:    ch = 8'h65;  // e
            4'd10:   ch = 8'h6E;  // n
            4'd11:   ch = 8'h67;  // g
            4'd12:   ch = 8'h74;  // t
            4'd13:   ch = 8'h68;  // h
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== hdl/hrbp_len_acc.sv =====
// Decimal digit step of the Content-Length accumulator with overflow detection.
module hrbp_len_acc (
    input  logic [7:0]                  data_byte,
    input  logic [hrbp_pkg::LEN_BITS-1:0] acc,
    output hrbp_pkg::acc_result_t       result
);
    import hrbp_pkg::*;

    logic [7:0]          diff;
    logic [LEN_BITS+3:0] wide;

    // acc * 10 + d never exceeds LEN_BITS + 4 bits, so the top nibble flags overflow.
    assign diff = data_byte - CH_ZERO;
    assign wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + (LEN_BITS + 4)'(diff[3:0]);

    assign result.is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign result.digit    = diff[3:0];
    assign result.overflow = |wide[LEN_BITS+3:LEN_BITS];
    assign result.value    = wide[LEN_BITS-1:0];

endmodule

// ===== hdl/http_request_byte_parser_top.sv =====
// Top level of the HTTP/1.1 request byte parser with its stream ports.
//
// The parser takes one request byte per transaction on the slave stream and
// returns exactly one tagged result transaction per input byte on the master
// stream, in order. Each result carries the byte, its class (method, URI,
// version, header name, header value, body or delimiter), a field-end flag,
// the parse status after this byte, the recognized method and the latest
// Content-Length value. The method must be GET or POST; a header whose name
// is exactly Content-Length has its leading decimal digits parsed, and after
// the blank line a POST with a nonzero length counts its body bytes down to
// completion. A missing digit, a length above 2^32 - 1 or an unknown method
// fails the request until a transaction with tuser (restart) set, which
// clears the parser before its own byte is processed. The whole state update
// is one pass of shallow logic plus the times-ten add of the length
// accumulator, from the accepted byte into the state and result registers,
// so a byte is accepted on every clock edge while the output register is
// empty or being taken, and a valid result appears in the cycle after
// acceptance. There is no clearing pass after reset.
module http_request_byte_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] restart
    input  logic        s_axis_tlast,   // chunk_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] byte_out, [9:8] parse_status,
                                        // [11:10] method_code, [43:12] body_length,
                                        // [47:44] zero
    output logic [3:0]  m_axis_tuser,   // [2:0] byte_class, [3] field_end
    output logic        m_axis_tlast    // chunk_last
);
    import hrbp_pkg::*;

    typedef enum logic [2:0] {
        PH_METHOD,
        PH_URI,
        PH_VERSION,
        PH_NAME,
        PH_VALUE,
        PH_BODY_LF,
        PH_BODY,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        DG_SKIP,
        DG_DIGITS,
        DG_STOPPED,
        DG_BAD
    } digit_t;

    // Parser state.
    phase_t              phase_reg, phase_next;
    logic [2:0]          meth_pos_reg, meth_pos_next;
    method_t             method_reg, method_next;
    logic [3:0]          name_pos_reg, name_pos_next;
    logic                match_ok_reg, match_ok_next;
    logic                len_active_reg, len_active_next;
    digit_t              digit_reg, digit_next;
    logic [LEN_BITS-1:0] length_reg, length_next;
    logic [LEN_BITS-1:0] body_left_reg, body_left_next;
    logic                failed_reg, failed_next;

    // Result register.
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    byte_class_t         out_class_reg, out_class_next;
    logic                out_fe_reg, out_fe_next;
    status_t             out_status_reg, out_status_next;
    method_t             out_method_reg, out_method_next;
    logic [BODY_LEN_W-1:0] out_len_reg, out_len_next;
    logic                out_last_reg, out_last_next;

    // State as seen by this byte, after an optional restart.
    phase_t              phase_cur;
    logic [2:0]          meth_pos_cur;
    method_t             method_cur;
    logic [3:0]          name_pos_cur;
    logic                match_ok_cur;
    logic                len_active_cur;
    digit_t              digit_cur;
    logic [LEN_BITS-1:0] length_cur;
    logic [LEN_BITS-1:0] body_left_cur;
    logic                failed_cur;

    logic                accept;
    logic                restart;
    logic [7:0]          c;
    acc_result_t         acc;
    logic [LEN_BITS-1:0] body_dec;
    logic [7:0]          meth_exp;
    byte_class_t         cls;
    logic                fe;

    assign c       = s_axis_tdata;
    assign restart = s_axis_tuser;

    // The output register frees up in the same cycle its result is taken.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign phase_cur      = restart ? PH_METHOD : phase_reg;
    assign meth_pos_cur   = restart ? MM_EMPTY : meth_pos_reg;
    assign method_cur     = restart ? METH_NONE : method_reg;
    assign name_pos_cur   = restart ? 4'd0 : name_pos_reg;
    assign match_ok_cur   = restart ? 1'b1 : match_ok_reg;
    assign len_active_cur = restart ? 1'b0 : len_active_reg;
    assign digit_cur      = restart ? DG_SKIP : digit_reg;
    assign length_cur     = restart ? '0 : length_reg;
    assign body_left_cur  = restart ? '0 : body_left_reg;
    assign failed_cur     = restart ? 1'b0 : failed_reg;

    hrbp_len_acc u_len_acc (
        .data_byte (c),
        .acc       (body_left_cur),
        .result    (acc)
    );

    // A body byte counts down, saturating at zero.
    assign body_dec = (body_left_cur != '0) ? body_left_cur - LEN_BITS'(1) : body_left_cur;
    assign meth_exp = meth_next_char(meth_pos_cur);

    always_comb
    begin
        phase_next      = phase_cur;
        meth_pos_next   = meth_pos_cur;
        method_next     = method_cur;
        name_pos_next   = name_pos_cur;
        match_ok_next   = match_ok_cur;
        len_active_next = len_active_cur;
        digit_next      = digit_cur;
        length_next     = length_cur;
        body_left_next  = body_left_cur;
        failed_next     = failed_cur;
        cls             = CLS_DELIM;
        fe              = 1'b0;

        // Once failed, every byte is a delimiter and nothing moves.
        if (!failed_cur)
        begin
            case (phase_cur)
                PH_METHOD:
                begin
                    if (c == CH_SPACE)
                    begin
                        fe = 1'b1;
                        if (match_ok_cur && meth_pos_cur == MM_GET_DONE)
                        begin
                            method_next = METH_GET;
                            phase_next  = PH_URI;
                        end
                        else if (match_ok_cur && meth_pos_cur == MM_POST_DONE)
                        begin
                            method_next = METH_POST;
                            phase_next  = PH_URI;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                        meth_pos_next = MM_EMPTY;
                        match_ok_next = 1'b1;
                    end
                    else
                    begin
                        cls = CLS_METHOD;
                        if (match_ok_cur)
                        begin
                            if (meth_pos_cur == MM_EMPTY && c == CH_G)
                                meth_pos_next = MM_G;
                            else if (meth_pos_cur == MM_EMPTY && c == CH_P)
                                meth_pos_next = MM_P;
                            else if (meth_pos_cur != MM_EMPTY && meth_exp != 8'h00
                                     && c == meth_exp)
                                meth_pos_next = meth_pos_cur + 3'd1;
                            else
                                match_ok_next = 1'b0;
                        end
                    end
                end
                PH_URI:
                begin
                    if (c == CH_SPACE)
                    begin
                        fe         = 1'b1;
                        phase_next = PH_VERSION;
                    end
                    else
                    begin
                        cls = CLS_URI;
                    end
                end
                PH_VERSION:
                begin
                    if (c == CH_CR)
                    begin
                        fe            = 1'b1;
                        phase_next    = PH_NAME;
                        name_pos_next = 4'd0;
                        match_ok_next = 1'b1;
                    end
                    else if (c != CH_LF)
                    begin
                        cls = CLS_VERSION;
                    end
                end
                PH_NAME:
                begin
                    if (c == CH_COLON)
                    begin
                        fe              = 1'b1;
                        len_active_next = match_ok_cur && (name_pos_cur == 4'(NAME_LEN));
                        digit_next      = DG_SKIP;
                        body_left_next  = '0;
                        phase_next      = PH_VALUE;
                    end
                    else if (c == CH_CR)
                    begin
                        // A bare CR at a header start ends the header block.
                        if (method_cur == METH_POST && length_cur != '0)
                        begin
                            body_left_next = length_cur;
                            phase_next     = PH_BODY_LF;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    else if (c != CH_LF)
                    begin
                        cls = CLS_NAME;
                        if (match_ok_cur && name_pos_cur < 4'(NAME_LEN)
                            && c == cl_name_char(name_pos_cur))
                            name_pos_next = name_pos_cur + 4'd1;
                        else
                            match_ok_next = 1'b0;
                    end
                end
                PH_VALUE:
                begin
                    if (c == CH_CR)
                    begin
                        fe = 1'b1;
                        if (len_active_cur)
                        begin
                            if (digit_cur == DG_DIGITS || digit_cur == DG_STOPPED)
                                length_next = body_left_cur;
                            else
                                failed_next = 1'b1;
                        end
                        body_left_next  = '0;
                        len_active_next = 1'b0;
                        digit_next      = DG_SKIP;
                        name_pos_next   = 4'd0;
                        match_ok_next   = 1'b1;
                        phase_next      = PH_NAME;
                    end
                    else if (c != CH_LF)
                    begin
                        cls = CLS_VALUE;
                        if (len_active_cur)
                        begin
                            case (digit_cur)
                                DG_SKIP:
                                begin
                                    if (c == CH_SPACE || c == CH_TAB)
                                    begin
                                        digit_next = DG_SKIP;
                                    end
                                    else if (acc.is_digit)
                                    begin
                                        body_left_next = LEN_BITS'(acc.digit);
                                        digit_next     = DG_DIGITS;
                                    end
                                    else
                                    begin
                                        digit_next = DG_BAD;
                                    end
                                end
                                DG_DIGITS:
                                begin
                                    if (!acc.is_digit)
                                        digit_next = DG_STOPPED;
                                    else if (acc.overflow)
                                        digit_next = DG_BAD;
                                    else
                                        body_left_next = acc.value;
                                end
                                default:
                                begin
                                    digit_next = digit_cur;
                                end
                            endcase
                        end
                    end
                end
                PH_BODY_LF:
                begin
                    phase_next = PH_BODY;
                    if (c != CH_LF)
                    begin
                        cls            = CLS_BODY;
                        body_left_next = body_dec;
                        if (body_dec == '0)
                        begin
                            fe         = 1'b1;
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_BODY:
                begin
                    cls            = CLS_BODY;
                    body_left_next = body_dec;
                    if (body_dec == '0)
                    begin
                        fe         = 1'b1;
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = phase_cur;
                end
            endcase
        end

        out_byte_next   = c;
        out_class_next  = cls;
        out_fe_next     = fe;
        out_method_next = method_next;
        out_len_next    = BODY_LEN_W'(length_next);
        out_last_next   = s_axis_tlast;
        if (failed_next)
            out_status_next = ST_FAILED;
        else if (phase_next == PH_DONE)
            out_status_next = ST_COMPLETE;
        else
            out_status_next = ST_INCOMPLETE;

        out_valid_next = accept || (out_valid_reg && !m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_METHOD;
            meth_pos_reg   <= MM_EMPTY;
            method_reg     <= METH_NONE;
            name_pos_reg   <= 4'd0;
            match_ok_reg   <= 1'b1;
            len_active_reg <= 1'b0;
            digit_reg      <= DG_SKIP;
            length_reg     <= '0;
            body_left_reg  <= '0;
            failed_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg      <= phase_next;
                meth_pos_reg   <= meth_pos_next;
                method_reg     <= method_next;
                name_pos_reg   <= name_pos_next;
                match_ok_reg   <= match_ok_next;
                len_active_reg <= len_active_next;
                digit_reg      <= digit_next;
                length_reg     <= length_next;
                body_left_reg  <= body_left_next;
                failed_reg     <= failed_next;
            end
        end
    end

    // Result payload needs no reset; it is qualified by out_valid_reg.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_byte_reg   <= out_byte_next;
            out_class_reg  <= out_class_next;
            out_fe_reg     <= out_fe_next;
            out_status_reg <= out_status_next;
            out_method_reg <= out_method_next;
            out_len_reg    <= out_len_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_len_reg, out_method_reg, out_status_reg, out_byte_reg};
    assign m_axis_tuser  = {out_fe_reg, out_class_reg};
    assign m_axis_tlast  = out_last_reg;

`include "assert_macros.svh"

    // A failure holds until a restart transaction arrives.
    `ASSERT_NEXT(a_fail_sticky, clk, rst_n, failed_reg && !(accept && restart), failed_reg)

    // A byte reported with a failed status is never tagged as part of a field.
    `ASSERT_SAME(a_fail_class, clk, rst_n, out_valid_reg && out_status_reg == ST_FAILED,
                 out_class_reg == CLS_DELIM)

    // The body byte that ends the body completes the request.
    `ASSERT_SAME(a_body_done, clk, rst_n,
                 out_valid_reg && out_class_reg == CLS_BODY && out_fe_reg,
                 out_status_reg == ST_COMPLETE)

endmodule

// ===== tb/sv/http_request_byte_parser_top_test.sv =====
// Self-checking stream testbench for the HTTP request byte parser top level.
`timescale 1ns / 1ps

// What is tested and how:
// Request bytes go in on the slave stream, one per transaction, and every
// accepted byte is run through a tagging model kept in this file. The model
// holds its own copy of the parser state (phase, method prefix, header name
// match, Content-Length digit state, body countdown and the sticky failure).
// It queues the expected tag for the byte: class, field end, status, method,
// length and chunk echo. A checker process compares every result transaction
// on the master stream, field by field, with the oldest queued tag.
//
// The stimulus starts with three short directed requests: an unknown method,
// a minimal GET that carries the extreme byte values, and a POST with a
// Content-Length header and a one-byte body. Random requests follow. Most of
// them are well formed with random content, and the rest are truncated,
// malformed or pure noise. Both stream sides idle at random, with one phase
// where neither side idles. In another phase the receiver holds off for a
// long stretch while the sender keeps offering bytes, so the parser stalls.
module http_request_byte_parser_top_test;

    import hrbp_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 200;

    localparam logic [63:0] LENGTH_MAX = (64'd1 << LEN_BITS) - 64'd1;

    // Reference spellings, first character in the highest byte.
    localparam logic [8*NAME_LEN-1:0] LENGTH_NAME = "Content-Length";
    localparam logic [8*3-1:0]        GET_TEXT    = "GET";
    localparam logic [8*4-1:0]        POST_TEXT   = "POST";

    // Where the parser is within the request.
    typedef enum logic [2:0] {
        STG_METHOD,
        STG_URI,
        STG_VERSION,
        STG_NAME,
        STG_VALUE,
        STG_BODY_LF,
        STG_BODY,
        STG_DONE
    } parse_stage_t;

    // Progress through the digits of a Content-Length value.
    typedef enum logic [1:0] {
        NUM_SKIP,
        NUM_DIGITS,
        NUM_AFTER,
        NUM_BAD
    } number_state_t;

    // Everything one result transaction is expected to carry.
    typedef struct packed {
        logic [7:0]  data;
        byte_class_t cls;
        logic        fe;
        status_t     status;
        method_t     meth;
        logic [31:0] blen;
        logic        last;
    } parse_tag_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] data_byte
    logic        s_axis_tuser = 1'b0;   // [0] restart
    logic        s_axis_tlast = 1'b0;   // chunk_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // [7:0] byte_out, [9:8] parse_status,
                                        // [11:10] method_code, [43:12] body_length,
                                        // [47:44] zero
    logic [3:0]  m_axis_tuser;          // [2:0] byte_class, [3] field_end
    logic        m_axis_tlast;          // chunk_last

    // Tags of accepted bytes whose result transaction has not arrived yet.
    parse_tag_t  expected_tags[$];
    parse_tag_t  oldest_tag;
    int          mismatch_count = 0;
    int          parsed_bytes = 0;
    int          quiet_cycles = 0;

    // Bytes of the request being built by the generator.
    logic [7:0]  req_bytes[$];

    // Handshake pacing flags for the sender and the receiver.
    bit          no_idle = 1'b0;
    bit          hold_request = 1'b0;

    // Tagging model state.
    parse_stage_t  stage;
    logic [2:0]    meth_prefix;
    method_t       meth_known;
    int            name_pos;
    bit            name_ok;
    bit            in_length_hdr;
    number_state_t num_state;
    logic [63:0]   length_reg;
    logic [63:0]   body_count;
    bit            failed;

    http_request_byte_parser_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Tagging model
    // ------------------------------------------------------------------

    // Puts the model back to the start of a request, as reset and restart do.
    function automatic void clear_parser();
        stage         = STG_METHOD;
        meth_prefix   = MM_EMPTY;
        meth_known    = METH_NONE;
        name_pos      = 0;
        name_ok       = 1'b1;
        in_length_hdr = 1'b0;
        num_state     = NUM_SKIP;
        length_reg    = 64'd0;
        body_count    = 64'd0;
        failed        = 1'b0;
    endfunction

    // The character that extends a partial GET or POST; zero once the
    // method is spelled out completely.
    function automatic logic [7:0] method_char_after(input logic [2:0] prefix);
        if (prefix >= MM_G && prefix < MM_GET_DONE)
            return GET_TEXT[8*(2 - prefix) +: 8];
        if (prefix >= MM_P && prefix < MM_POST_DONE)
            return POST_TEXT[8*(3 - (prefix - MM_P + 1)) +: 8];
        return 8'h00;
    endfunction

    // One body byte: counts down and ends the request at zero.
    function automatic void count_body(output byte_class_t cls, output logic fe);
        cls = CLS_BODY;
        fe  = 1'b0;
        if (body_count > 0)
            body_count = body_count - 1;
        if (body_count == 0)
        begin
            fe    = 1'b1;
            stage = STG_DONE;
        end
    endfunction

    // Tags one accepted byte and advances the model. The byte counts as
    // parsed unless the request had already failed or completed.
    function automatic void tag_byte(input logic [7:0] c, input logic restart,
                                     input logic chunk_end, output parse_tag_t t,
                                     output bit parsed);
        byte_class_t cls;
        logic        fe;
        bit          is_digit;
        logic [63:0] digit;

        cls = CLS_DELIM;
        fe  = 1'b0;
        if (restart)
            clear_parser();
        parsed = !failed && stage != STG_DONE;

        if (!failed)
        begin
            case (stage)
                STG_METHOD:
                begin
                    if (c == CH_SPACE)
                    begin
                        fe = 1'b1;
                        if (name_ok && meth_prefix == MM_GET_DONE)
                            meth_known = METH_GET;
                        else if (name_ok && meth_prefix == MM_POST_DONE)
                            meth_known = METH_POST;
                        else
                            failed = 1'b1;
                        meth_prefix = MM_EMPTY;
                        name_ok     = 1'b1;
                        if (!failed)
                            stage = STG_URI;
                    end
                    else
                    begin
                        cls = CLS_METHOD;
                        if (name_ok)
                        begin
                            if (meth_prefix == MM_EMPTY && c == CH_G)
                                meth_prefix = MM_G;
                            else if (meth_prefix == MM_EMPTY && c == CH_P)
                                meth_prefix = MM_P;
                            else if (meth_prefix != MM_EMPTY &&
                                     method_char_after(meth_prefix) != 8'h00 &&
                                     c == method_char_after(meth_prefix))
                                meth_prefix = meth_prefix + 3'd1;
                            else
                                name_ok = 1'b0;
                        end
                    end
                end
                STG_URI:
                begin
                    if (c == CH_SPACE)
                    begin
                        fe    = 1'b1;
                        stage = STG_VERSION;
                    end
                    else
                        cls = CLS_URI;
                end
                STG_VERSION:
                begin
                    if (c == CH_CR)
                    begin
                        fe       = 1'b1;
                        stage    = STG_NAME;
                        name_pos = 0;
                        name_ok  = 1'b1;
                    end
                    else if (c != CH_LF)
                        cls = CLS_VERSION;
                end
                STG_NAME:
                begin
                    if (c == CH_COLON)
                    begin
                        fe            = 1'b1;
                        in_length_hdr = name_ok && name_pos == NAME_LEN;
                        num_state     = NUM_SKIP;
                        body_count    = 64'd0;
                        stage         = STG_VALUE;
                    end
                    else if (c == CH_CR)
                    begin
                        // The blank line: a POST with a length goes on to its body.
                        if (meth_known == METH_POST && length_reg > 0)
                        begin
                            body_count = length_reg;
                            stage      = STG_BODY_LF;
                        end
                        else
                            stage = STG_DONE;
                    end
                    else if (c != CH_LF)
                    begin
                        cls = CLS_NAME;
                        if (name_ok && name_pos < NAME_LEN &&
                            c == LENGTH_NAME[8*(NAME_LEN - 1 - name_pos) +: 8])
                            name_pos = name_pos + 1;
                        else
                            name_ok = 1'b0;
                    end
                end
                STG_VALUE:
                begin
                    if (c == CH_CR)
                    begin
                        fe = 1'b1;
                        if (in_length_hdr)
                        begin
                            if (num_state == NUM_DIGITS || num_state == NUM_AFTER)
                                length_reg = body_count;
                            else
                                failed = 1'b1;
                        end
                        body_count    = 64'd0;
                        in_length_hdr = 1'b0;
                        num_state     = NUM_SKIP;
                        name_pos      = 0;
                        name_ok       = 1'b1;
                        stage         = STG_NAME;
                    end
                    else if (c != CH_LF)
                    begin
                        cls = CLS_VALUE;
                        if (in_length_hdr)
                        begin
                            is_digit = c >= CH_ZERO && c <= CH_NINE;
                            digit    = {56'd0, c - CH_ZERO};
                            case (num_state)
                                NUM_SKIP:
                                begin
                                    if (c == CH_SPACE || c == CH_TAB)
                                        num_state = NUM_SKIP;
                                    else if (is_digit)
                                    begin
                                        body_count = digit;
                                        num_state  = NUM_DIGITS;
                                    end
                                    else
                                        num_state = NUM_BAD;
                                end
                                NUM_DIGITS:
                                begin
                                    // The first non-digit freezes the value; a digit
                                    // that would carry past the width spoils it.
                                    if (!is_digit)
                                        num_state = NUM_AFTER;
                                    else if (body_count > (LENGTH_MAX - digit) / 10)
                                        num_state = NUM_BAD;
                                    else
                                        body_count = body_count * 10 + digit;
                                end
                                default:
                                    num_state = num_state;
                            endcase
                        end
                    end
                end
                STG_BODY_LF:
                begin
                    // One line feed may follow the blank line; anything else is body.
                    if (c == CH_LF)
                        stage = STG_BODY;
                    else
                    begin
                        stage = STG_BODY;
                        count_body(cls, fe);
                    end
                end
                STG_BODY:
                    count_body(cls, fe);
                default:
                    stage = STG_DONE;
            endcase
        end

        t.data   = c;
        t.cls    = cls;
        t.fe     = fe;
        t.status = failed ? ST_FAILED : (stage == STG_DONE ? ST_COMPLETE : ST_INCOMPLETE);
        t.meth   = meth_known;
        t.blen   = length_reg[31:0];
        t.last   = chunk_end;
    endfunction

    // ------------------------------------------------------------------
    // Request generator
    // ------------------------------------------------------------------

    function automatic void push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            req_bytes.push_back(s[i]);
    endfunction

    function automatic void push_decimal(input logic [63:0] v);
        logic [7:0] digits[$];

        do
        begin
            digits.push_front(8'(CH_ZERO + v % 10));
            v = v / 10;
        end
        while (v != 0);
        foreach (digits[i])
            req_bytes.push_back(digits[i]);
    endfunction

    function automatic logic [7:0] byte_other_than(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] v;

        do
            v = 8'($urandom_range(255));
        while (v == a || v == b);
        return v;
    endfunction

    // Builds one request. Most are well formed with random content; some use
    // a bad method, a malformed length, a mistyped header name or get cut off.
    function automatic void build_request();
        int          kind;
        int          headers;
        int          keep;
        int          plan_body;
        bit          is_post;
        logic [63:0] v;

        req_bytes.delete();
        plan_body = 0;
        is_post   = 1'b0;

        kind = $urandom_range(99);
        if (kind < 45)
            push_str("GET");
        else if (kind < 90)
        begin
            push_str("POST");
            is_post = 1'b1;
        end
        else
        begin
            case ($urandom_range(4))
                0: push_str("GE");
                1: push_str("POSTS");
                2: push_str("PUT");
                3: push_str("");
                default:
                    repeat ($urandom_range(1, 4))
                        req_bytes.push_back(byte_other_than(CH_SPACE, CH_SPACE));
            endcase
        end
        req_bytes.push_back(CH_SPACE);

        // URI: any bytes but a space.
        repeat ($urandom_range(0, 6))
            req_bytes.push_back(byte_other_than(CH_SPACE, CH_SPACE));
        req_bytes.push_back(CH_SPACE);

        if ($urandom_range(1))
            push_str("HTTP/1.1");
        else
            repeat ($urandom_range(0, 3))
                req_bytes.push_back($urandom_range(3) == 0 ? CH_LF :
                                    byte_other_than(CH_CR, CH_CR));
        req_bytes.push_back(CH_CR);
        if ($urandom_range(9) < 7)
            req_bytes.push_back(CH_LF);

        headers = $urandom_range(0, 3);
        if (is_post && headers == 0 && $urandom_range(9) < 8)
            headers = 1;
        for (int h = 0; h < headers; h++)
        begin
            if ((is_post && h == 0 && $urandom_range(9) < 8) || $urandom_range(9) < 3)
            begin
                push_str("Content-Length");
                req_bytes.push_back(CH_COLON);
                repeat ($urandom_range(0, 2))
                    req_bytes.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
                if ($urandom_range(9) == 0)
                    push_str("00");
                case ($urandom_range(9))
                    6:
                    begin
                        push_str("0");
                        plan_body = 0;
                    end
                    7:
                    begin
                        // No digit at all before something else.
                        if ($urandom_range(1))
                            push_str("x12");
                    end
                    8:
                    begin
                        case ($urandom_range(2))
                            0: push_decimal(LENGTH_MAX);
                            1: push_decimal(LENGTH_MAX + 1);
                            default: push_decimal(64'd99999999999);
                        endcase
                        plan_body = 3;
                    end
                    9:
                    begin
                        push_decimal({32'd0, $urandom()});
                        plan_body = 3;
                    end
                    default:
                    begin
                        v = 64'($urandom_range(1, 24));
                        push_decimal(v);
                        plan_body = int'(v);
                    end
                endcase
                if ($urandom_range(4) == 0)
                    push_str("; q=9");
            end
            else
            begin
                case ($urandom_range(4))
                    0: push_str("Host");
                    1: push_str("content-length");
                    2: push_str("Content-Lengthy");
                    3: push_str("Content-Lengt");
                    default:
                        repeat ($urandom_range(0, 6))
                            req_bytes.push_back(byte_other_than(CH_CR, CH_COLON));
                endcase
                req_bytes.push_back(CH_COLON);
                repeat ($urandom_range(0, 6))
                    req_bytes.push_back(byte_other_than(CH_CR, CH_CR));
            end
            req_bytes.push_back(CH_CR);
            if ($urandom_range(9) < 7)
                req_bytes.push_back(CH_LF);
        end

        // Blank line, then the body of a POST.
        req_bytes.push_back(CH_CR);
        if (is_post && plan_body > 0)
        begin
            if ($urandom_range(9) < 7)
                req_bytes.push_back(CH_LF);
            repeat (plan_body)
                req_bytes.push_back(8'($urandom_range(255)));
        end
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 3))
                req_bytes.push_back(8'($urandom_range(255)));

        if ($urandom_range(99) < 8)
        begin
            keep = $urandom_range(1, req_bytes.size());
            while (req_bytes.size() > keep)
                void'(req_bytes.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------
    // Stream driving and checking
    // ------------------------------------------------------------------

    // Offers one byte, waits for its transaction and queues the expected tag.
    task automatic send_byte(input logic [7:0] b, input logic restart, input logic chunk_end);
        parse_tag_t t;
        bit         parsed;

        if (!no_idle)
        begin
            while ($urandom_range(99) < 33)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= restart;
        s_axis_tlast  <= chunk_end;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tag_byte(b, restart, chunk_end, t, parsed);
        expected_tags.push_back(t);
        if (parsed)
            parsed_bytes++;
    endtask

    // Sends the built request, restarting the parser on its first byte in
    // most cases. A rare restart in the middle cuts the request short.
    task automatic send_request();
        bit with_restart;

        with_restart = $urandom_range(19) != 0;
        foreach (req_bytes[i])
            send_byte(req_bytes[i],
                      (i == 0 && with_restart) || $urandom_range(199) == 0,
                      $urandom_range(7) == 0 ||
                      (i == req_bytes.size() - 1 && $urandom_range(1) == 1));
    endtask

    // Raw bytes with random restart and chunk marks.
    task automatic send_noise();
        repeat ($urandom_range(1, 10))
            send_byte(8'($urandom_range(255)), $urandom_range(3) == 0,
                      $urandom_range(1) == 1);
    endtask

    // Lowers valid and waits until every queued tag has been matched.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_tags.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        // Printing stops after a while so a broken build cannot flood the log.
        if (mismatch_count < MAX_REPORTS)
            $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Every result transaction is checked against the oldest queued tag.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_tags.size() == 0)
                report_mismatch("result with no byte pending", {16'd0, m_axis_tdata}, 64'd0);
            else
            begin
                oldest_tag = expected_tags.pop_front();
                if (m_axis_tdata[7:0] !== oldest_tag.data)
                    report_mismatch("byte_out", 64'(m_axis_tdata[7:0]),
                                    64'(oldest_tag.data));
                if (m_axis_tuser[2:0] !== oldest_tag.cls)
                    report_mismatch("byte_class", 64'(m_axis_tuser[2:0]),
                                    64'(oldest_tag.cls));
                if (m_axis_tuser[3] !== oldest_tag.fe)
                    report_mismatch("field_end", 64'(m_axis_tuser[3]), 64'(oldest_tag.fe));
                if (m_axis_tdata[9:8] !== oldest_tag.status)
                    report_mismatch("parse_status", 64'(m_axis_tdata[9:8]),
                                    64'(oldest_tag.status));
                if (m_axis_tdata[11:10] !== oldest_tag.meth)
                    report_mismatch("method_code", 64'(m_axis_tdata[11:10]),
                                    64'(oldest_tag.meth));
                if (m_axis_tdata[43:12] !== oldest_tag.blen)
                    report_mismatch("body_length", 64'(m_axis_tdata[43:12]),
                                    64'(oldest_tag.blen));
                if (m_axis_tdata[47:44] !== 4'd0)
                    report_mismatch("tdata padding", 64'(m_axis_tdata[47:44]), 64'd0);
                if (m_axis_tlast !== oldest_tag.last)
                    report_mismatch("chunk_last", 64'(m_axis_tlast), 64'(oldest_tag.last));
            end
        end
    end

    // Result side: random stalls, none while the steady phase runs, and one
    // long hold-off when a test asks for it.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
                m_axis_tready <= no_idle || $urandom_range(99) >= 33;
        end
    end

    // Ends the run if no transaction moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("http_request_byte_parser_top regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // An empty method fails at once; the next byte finds the failure sticky.
    task automatic test_unknown_method();
        send_byte(CH_SPACE, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        drain_results();
    endtask

    // Shortest GET: extreme bytes in the URI, an empty version, the blank
    // line completing it, and one trailing byte that changes nothing.
    task automatic test_minimal_get();
        req_bytes.delete();
        push_str("GET ");
        req_bytes.push_back(8'h00);
        req_bytes.push_back(8'hFF);
        req_bytes.push_back(CH_SPACE);
        req_bytes.push_back(CH_CR);
        req_bytes.push_back(CH_CR);
        req_bytes.push_back(8'h51);
        foreach (req_bytes[i])
            send_byte(req_bytes[i], i == 0, i == req_bytes.size() - 1);
        drain_results();
    endtask

    // POST with a tab before a one-digit length; the line feed after the
    // blank line is skipped and the single body byte completes the request.
    task automatic test_post_length();
        req_bytes.delete();
        push_str("POST  ");
        req_bytes.push_back(CH_CR);
        push_str("Content-Length:");
        req_bytes.push_back(CH_TAB);
        push_str("1");
        req_bytes.push_back(CH_CR);
        req_bytes.push_back(CH_CR);
        req_bytes.push_back(CH_LF);
        push_str("Z");
        foreach (req_bytes[i])
            send_byte(req_bytes[i], i == 0, 1'b0);
        drain_results();
    endtask

    task automatic run_requests(input int target);
        while (parsed_bytes < target)
        begin
            if ($urandom_range(99) < 6)
                send_noise();
            else
            begin
                build_request();
                send_request();
            end
        end
    endtask

    task automatic test_random_requests();
        run_requests(1000);
        drain_results();
    endtask

    // The receiver stops for a long stretch while bytes keep coming, so the
    // parser must hold its output and stop accepting input.
    task automatic test_back_pressure();
        hold_request = 1'b1;
        run_requests(parsed_bytes + 130);
        drain_results();
    endtask

    // Neither side idles: one byte per clock wherever the parser allows it.
    task automatic test_steady_stream();
        no_idle = 1'b1;
        run_requests(parsed_bytes + 300);
        drain_results();
        no_idle = 1'b0;
    endtask

    initial
    begin
        clear_parser();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unknown_method();
        test_minimal_get();
        test_post_length();
        test_random_requests();
        test_back_pressure();
        test_steady_stream();

        if (expected_tags.size() != 0)
            report_mismatch("results never delivered", 64'(expected_tags.size()), 64'd0);
        if (mismatch_count == 0)
            $display("http_request_byte_parser_top regression: pass");
        else
            $display("http_request_byte_parser_top regression: fail");
        $finish;
    end

endmodule
